// ===== hw/rtl/playlist_signature_detector_unit_assert.svh =====
// assertion macros for the playlist signature detector
`ifndef PLAYLIST_SIGNATURE_DETECTOR_UNIT_ASSERT_SVH
`define PLAYLIST_SIGNATURE_DETECTOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// checked property, sampled on clk_i, off while rst_ni is low
`define PSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("playlist detector check failed");
// checked property that also holds through reset
`define PSD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("playlist detector check failed");
`else
`define PSD_ASSERT(lbl, prop)
`define PSD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== hw/rtl/psd_pkg.sv =====
// constant strings and character lookups for the playlist signature detector
package psd_pkg;

  localparam int unsigned NumTags = 8;
  localparam int unsigned HdrLen  = 7;
  localparam int unsigned PfxLen  = 6;
  localparam int unsigned TagMax  = 14;

  localparam logic [8*HdrLen-1:0] HdrStr = "#EXTM3U";
  localparam logic [8*PfxLen-1:0] PfxStr = "EXT-X-";

  localparam logic [3:0] TagLen [NumTags] = '{
    4'd14, 4'd14, 4'd3, 4'd11, 4'd7, 4'd10, 4'd13, 4'd7
  };

  function automatic logic [7:0] hdr_char(logic [3:0] pos);
    if (pos > 4'(HdrLen - 1)) return 8'h00;
    return HdrStr[8*(HdrLen-1-int'(pos)) +: 8];
  endfunction

  function automatic logic [7:0] pfx_char(logic [3:0] pos);
    if (pos > 4'(PfxLen - 1)) return 8'h00;
    return PfxStr[8*(PfxLen-1-int'(pos)) +: 8];
  endfunction

  // tag words padded with spaces to the longest word
  function automatic logic [7:0] tag_char(logic [2:0] k, logic [3:0] pos);
    logic [8*TagMax-1:0] w;
    case (k)
      3'd0:    w = "TARGETDURATION";
      3'd1:    w = "MEDIA-SEQUENCE";
      3'd2:    w = "KEY           ";
      3'd3:    w = "ALLOW-CACHE   ";
      3'd4:    w = "ENDLIST       ";
      3'd5:    w = "STREAM-INF    ";
      3'd6:    w = "DISCONTINUITY ";
      3'd7:    w = "VERSION       ";
      default: w = '0;
    endcase
    if (pos > 4'(TagMax - 1)) return 8'h00;
    return w[8*(TagMax-1-int'(pos)) +: 8];
  endfunction

endpackage

// ===== hw/rtl/playlist_signature_detector_unit.sv =====
// playlist signature detector: top level with input and result registers
// usage
//   input channel: one text byte per transfer on text_byte_i, last_byte_i
//   marks the final byte of a text; valid/stall handshake
//   output channel: one transfer per text, on its last byte, carrying
//   is_playlist_o (header "#EXTM3U" seen and then a known EXT-X- tag)
//   a zero byte ends the text early; bytes after it are ignored until last
// datapath
//   a byte is held in the input register and folded into the match state
//   when it leaves it; the verdict of a last byte is loaded into the result
//   register on that same edge and drives the output from there
// throughput
//   one byte per cycle while not stalled, as the state update against the
//   constant strings is combinational; only a last byte that finds the result
//   register full and stalled holds the input register
// reset
//   rst_ni low clears the valid bits of both registers and the match state
//   (header phase)
// back-pressure
//   a stalled result holds its value; non-last bytes keep flowing, and the
//   input side stalls only when a second verdict is waiting to be written
module playlist_signature_detector_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_playlist_o
);
  import psd_pkg::*;

  `include "playlist_signature_detector_unit_assert.svh"

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SEEK,
    PH_PREFIX,
    PH_TAG,
    PH_HALT
  } phase_e;

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // match state
  phase_e     phase_q, phase_d;
  logic [3:0] pos_q, pos_d;
  logic [7:0] cand_q, cand_d;
  logic       verdict_q, verdict_d;

  // result register
  logic       out_valid_q, out_valid_d;
  logic       is_playlist_q;

  logic       in_take;
  logic       s1_adv;
  logic       res_load;

  // feed outputs before the end-of-text reset
  phase_e     f_phase;
  logic [3:0] f_pos;
  logic [7:0] f_cand;
  logic       f_verdict;
  logic [7:0] tag_match;
  logic [7:0] tag_final;
  logic [7:0] tag_keep;

  // a last byte needs a free (or draining) result register
  assign s1_adv     = s1_valid_q && (!s1_last_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;
  assign res_load   = s1_adv && s1_last_q;

  assign s1_valid_d = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  // per-tag compare of the current byte
  always_comb begin
    for (int k = 0; k < NumTags; k++) begin
      tag_match[k] = cand_q[k] && (pos_q < TagLen[k]) &&
                     (s1_byte_q == tag_char(3'(k), pos_q));
      tag_final[k] = tag_match[k] && ((pos_q + 4'd1) == TagLen[k]);
      tag_keep[k]  = tag_match[k] && !tag_final[k];
    end
  end

  always_comb begin
    f_phase   = phase_q;
    f_pos     = pos_q;
    f_cand    = cand_q;
    f_verdict = verdict_q;
    if (phase_q == PH_HALT) begin
      // text over, ignore
    end else if (s1_byte_q == 8'h00) begin
      f_phase = PH_HALT;
    end else begin
      case (phase_q)
        PH_HEADER: begin
          if (s1_byte_q == hdr_char(pos_q) && pos_q < 4'(HdrLen)) begin
            if (pos_q == 4'(HdrLen - 1)) begin
              f_phase = PH_SEEK;
              f_pos   = '0;
            end else begin
              f_pos = pos_q + 4'd1;
            end
          end else begin
            f_phase = PH_HALT;
          end
        end
        PH_PREFIX: begin
          if (s1_byte_q == pfx_char(pos_q) && pos_q < 4'(PfxLen)) begin
            if (pos_q == 4'(PfxLen - 1)) begin
              f_phase = PH_TAG;
              f_pos   = '0;
              f_cand  = '1;
            end else begin
              f_pos = pos_q + 4'd1;
            end
          end else begin
            // mismatch: look at this byte again as a possible '#'
            f_phase = (s1_byte_q == "#") ? PH_PREFIX : PH_SEEK;
            f_pos   = '0;
          end
        end
        PH_TAG: begin
          if (|tag_final) begin
            f_verdict = 1'b1;
            f_phase   = PH_HALT;
          end else begin
            f_cand = tag_keep;
            if (|tag_keep) begin
              f_pos = pos_q + 4'd1;
            end else begin
              f_phase = (s1_byte_q == "#") ? PH_PREFIX : PH_SEEK;
              f_pos   = '0;
            end
          end
        end
        default: begin
          // seeking a '#'
          f_phase = (s1_byte_q == "#") ? PH_PREFIX : PH_SEEK;
          f_pos   = '0;
        end
      endcase
    end
  end

  // commit the byte; a last byte returns the state to its reset values
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    cand_d    = cand_q;
    verdict_d = verdict_q;
    if (s1_adv) begin
      if (s1_last_q) begin
        phase_d   = PH_HEADER;
        pos_d     = '0;
        cand_d    = '1;
        verdict_d = 1'b0;
      end else begin
        phase_d   = f_phase;
        pos_d     = f_pos;
        cand_d    = f_cand;
        verdict_d = f_verdict;
      end
    end
  end

  assign out_valid_d = res_load ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      phase_q       <= PH_HEADER;
      pos_q         <= '0;
      cand_q        <= '1;
      verdict_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      is_playlist_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      cand_q      <= cand_d;
      verdict_q   <= verdict_d;
      out_valid_q <= out_valid_d;
      if (res_load) begin
        is_playlist_q <= f_verdict;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= text_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign is_playlist_o = is_playlist_q;

  // a found tag always halts matching
  `PSD_ASSERT(a_verdict_halts, verdict_q |-> (phase_q == PH_HALT))
  // tag phase always has at least one live candidate
  `PSD_ASSERT(a_tag_has_cand, (phase_q == PH_TAG) |-> (cand_q != 8'h00))
  // prefix position stays inside "EXT-X-"
  `PSD_ASSERT(a_prefix_pos, (phase_q == PH_PREFIX) |-> (pos_q < 4'(PfxLen)))
  // input only stalls behind a held verdict with another last byte waiting
  `PSD_ASSERT_ALWAYS(a_stall_cause,
    in_stall_o |-> (s1_valid_q && s1_last_q && out_valid_q && out_stall_i))

endmodule
